/* hw/rtl/jsu_pkg.sv */
package jsu_pkg;

  // Parser position inside a quoted string
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STR,
    PH_ESC,
    PH_HEX,
    PH_HI_BS,
    PH_HI_U,
    PH_LOWHEX
  } phase_e;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_NO_QUOTE    = 4'd1,
    ERR_CONTROL     = 4'd2,
    ERR_TRUNC_ESC   = 4'd3,
    ERR_BAD_ESC     = 4'd4,
    ERR_TRUNC_HEX   = 4'd5,
    ERR_BAD_HEX     = 4'd6,
    ERR_NO_LOW      = 4'd7,
    ERR_BAD_LOW     = 4'd8,
    ERR_LONE_LOW    = 4'd9,
    ERR_UNTERM      = 4'd10
  } err_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChU = 8'h75;
  localparam logic [7:0] ChCtlLimit = 8'h20;

  // Surrogate ranges are identified by the top six bits of the code unit
  localparam logic [5:0] HiSurrTag = 6'b110110;
  localparam logic [5:0] LoSurrTag = 6'b110111;
  localparam logic [10:0] SuppOffset = 11'h040;  // 0x10000 >> 10

  typedef struct packed {
    phase_e      phase;
    logic [15:0] acc;
    logic [1:0]  digits;
    logic [9:0]  pend;
  } pstate_t;

  // Results of one item: up to four UTF-8 bytes, or one status result
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            status;
    logic            done;
    err_e            err;
  } bundle_t;

  function automatic bundle_t utf8_encode(input logic [20:0] cp);
    bundle_t b;
    b = '0;
    b.err = ERR_NONE;
    if (cp <= 21'h7F) begin
      b.bytes[0] = cp[7:0];
      b.cnt = 3'd1;
    end else if (cp <= 21'h7FF) begin
      b.bytes[0] = {3'b110, cp[10:6]};
      b.bytes[1] = {2'b10, cp[5:0]};
      b.cnt = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      b.bytes[0] = {4'b1110, cp[15:12]};
      b.bytes[1] = {2'b10, cp[11:6]};
      b.bytes[2] = {2'b10, cp[5:0]};
      b.cnt = 3'd3;
    end else begin
      b.bytes[0] = {5'b11110, cp[20:18]};
      b.bytes[1] = {2'b10, cp[17:12]};
      b.bytes[2] = {2'b10, cp[11:6]};
      b.bytes[3] = {2'b10, cp[5:0]};
      b.cnt = 3'd4;
    end
    return b;
  endfunction

endpackage

/* hw/rtl/jsu_decode.sv */
module jsu_decode (
  input  jsu_pkg::pstate_t st_i,
  input  logic [7:0]       byte_i,
  input  logic             start_i,
  input  logic             eoi_i,
  output jsu_pkg::pstate_t st_o,
  output jsu_pkg::bundle_t res_o
);
  import jsu_pkg::*;

  logic [3:0]  nib;
  logic        nib_ok;
  logic [15:0] unit;
  logic [20:0] cp_pair;

  always_comb begin
    nib_ok = 1'b1;
    nib = byte_i[3:0];
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      nib = byte_i[3:0];
    end else if ((byte_i >= 8'h61 && byte_i <= 8'h66) ||
                 (byte_i >= 8'h41 && byte_i <= 8'h46)) begin
      nib = 4'(byte_i[2:0] + 3'd1) + 4'd8;
    end else begin
      nib_ok = 1'b0;
    end
  end

  assign unit    = {st_i.acc[11:0], nib};
  assign cp_pair = {11'({1'b0, st_i.pend} + SuppOffset), unit[9:0]};

  always_comb begin
    pstate_t idle_st;
    bundle_t stat;
    idle_st = '0;
    idle_st.phase = PH_IDLE;
    st_o = st_i;
    res_o = '0;
    res_o.err = ERR_NONE;
    stat = '0;
    stat.status = 1'b1;
    stat.cnt = 3'd1;
    stat.err = ERR_NONE;

    if (eoi_i) begin
      st_o = idle_st;
      res_o = stat;
      unique case (st_i.phase)
        PH_STR:    res_o.err = ERR_UNTERM;
        PH_ESC:    res_o.err = ERR_TRUNC_ESC;
        PH_HEX:    res_o.err = ERR_TRUNC_HEX;
        PH_HI_BS,
        PH_HI_U,
        PH_LOWHEX: res_o.err = ERR_NO_LOW;
        default:   res_o.cnt = 3'd0;
      endcase
    end else if (start_i) begin
      st_o = idle_st;
      if (byte_i == ChQuote) begin
        st_o.phase = PH_STR;
      end else begin
        res_o = stat;
        res_o.err = ERR_NO_QUOTE;
      end
    end else begin
      unique case (st_i.phase)
        PH_STR: begin
          if (byte_i == ChQuote) begin
            st_o = idle_st;
            res_o = stat;
            res_o.done = 1'b1;
          end else if (byte_i < ChCtlLimit) begin
            st_o = idle_st;
            res_o = stat;
            res_o.err = ERR_CONTROL;
          end else if (byte_i == ChBslash) begin
            st_o.phase = PH_ESC;
          end else begin
            res_o.bytes[0] = byte_i;
            res_o.cnt = 3'd1;
          end
        end
        PH_ESC: begin
          st_o.phase = PH_STR;
          res_o.cnt = 3'd1;
          unique case (byte_i)
            ChQuote, ChBslash, ChSlash: res_o.bytes[0] = byte_i;
            8'h62: res_o.bytes[0] = 8'h08;
            8'h66: res_o.bytes[0] = 8'h0C;
            8'h6E: res_o.bytes[0] = 8'h0A;
            8'h72: res_o.bytes[0] = 8'h0D;
            8'h74: res_o.bytes[0] = 8'h09;
            ChU: begin
              res_o.cnt = 3'd0;
              st_o.phase = PH_HEX;
              st_o.acc = '0;
              st_o.digits = '0;
            end
            default: begin
              st_o = idle_st;
              res_o = stat;
              res_o.err = ERR_BAD_ESC;
            end
          endcase
        end
        PH_HEX, PH_LOWHEX: begin
          if (!nib_ok) begin
            st_o = idle_st;
            res_o = stat;
            res_o.err = ERR_BAD_HEX;
          end else if (st_i.digits != 2'd3) begin
            st_o.acc = unit;
            st_o.digits = st_i.digits + 2'd1;
          end else begin
            st_o.acc = '0;
            st_o.digits = '0;
            if (st_i.phase == PH_HEX) begin
              if (unit[15:10] == HiSurrTag) begin
                st_o.pend = unit[9:0];
                st_o.phase = PH_HI_BS;
              end else if (unit[15:10] == LoSurrTag) begin
                st_o = idle_st;
                res_o = stat;
                res_o.err = ERR_LONE_LOW;
              end else begin
                st_o.phase = PH_STR;
                res_o = utf8_encode({5'd0, unit});
              end
            end else begin
              if (unit[15:10] != LoSurrTag) begin
                st_o = idle_st;
                res_o = stat;
                res_o.err = ERR_BAD_LOW;
              end else begin
                st_o.pend = '0;
                st_o.phase = PH_STR;
                res_o = utf8_encode(cp_pair);
              end
            end
          end
        end
        PH_HI_BS: begin
          if (byte_i != ChBslash) begin
            st_o = idle_st;
            res_o = stat;
            res_o.err = ERR_NO_LOW;
          end else begin
            st_o.phase = PH_HI_U;
          end
        end
        PH_HI_U: begin
          if (byte_i != ChU) begin
            st_o = idle_st;
            res_o = stat;
            res_o.err = ERR_NO_LOW;
          end else begin
            st_o.phase = PH_LOWHEX;
            st_o.acc = '0;
            st_o.digits = '0;
          end
        end
        default: st_o = idle_st;
      endcase
    end
  end

endmodule

/* hw/rtl/json_string_unescape_utf8_top.sv */
// Channel  Dir  tdata            tuser                                   tlast
// s_axis   in   data_byte[7:0]   [0] start_string, [1] end_of_input      -
// m_axis   out  out_byte[7:0]    [0] out_valid, [1] string_done,         last
//                                [5:2] error_code
//
// One input item is parsed per cycle while the input is ready; its results (none, one status item or
// one to four UTF-8 bytes) land in a result register in the same edge.
// The result register drains one item per cycle while downstream is ready, so an item that yields
// several results holds the input side while they drain; the next item is
// taken in the cycle the last result leaves. Reset (rst_ni low, async)
// puts the parser in idle and empties the result register. Downstream
// stalls freeze the result register and back-pressure the input.
module json_string_unescape_utf8_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0] s_axis_tuser_i,   // [0] start_string, [1] end_of_input
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [5:0] m_axis_tuser_o,   // [0] out_valid, [1] string_done, [5:2] error_code
  output logic       m_axis_tlast_o
);
  import jsu_pkg::*;

  pstate_t st_q, st_d;
  bundle_t res_d, res_q;
  logic [2:0] rem_q;   // results still to deliver
  logic [1:0] idx_q;   // which result of the bundle is on the port
  logic push, pop;

  jsu_decode u_dec (
    .st_i   (st_q),
    .byte_i (s_axis_tdata_i),
    .start_i(s_axis_tuser_i[0]),
    .eoi_i  (s_axis_tuser_i[1]),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // Accept while empty, or while the final result is leaving this cycle
  assign s_axis_tready_o = (rem_q == 3'd0) || (rem_q == 3'd1 && m_axis_tready_i);
  assign push = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (rem_q != 3'd0);
  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  // All-zero state is idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      rem_q      <= '0;
      idx_q      <= '0;
    end else begin
      if (push) begin
        st_q  <= st_d;
        rem_q <= res_d.cnt;
        idx_q <= '0;
      end else if (pop) begin
        rem_q <= rem_q - 3'd1;
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q <= res_d;
    end
  end

  // Status items carry zero bytes, so the byte lane needs no extra mux
  assign m_axis_tdata_o = res_q.bytes[idx_q];
  assign m_axis_tuser_o = {res_q.err, res_q.done, !res_q.status};
  assign m_axis_tlast_o = (rem_q == 3'd1);

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 3'd4)
    else $error("result count out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(rem_q) && $stable(idx_q))
    else $error("result queue moved during stall");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tlast_o)
    else $error("status item not marked last");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tuser_o[5:1] == 5'd0)
    else $error("byte item carries status");

endmodule
